// ===== rtl/paged_mono_framebuffer_engine_assert.svh =====
`ifndef PAGED_MONO_FRAMEBUFFER_ENGINE_ASSERT_SVH
`define PAGED_MONO_FRAMEBUFFER_ENGINE_ASSERT_SVH

// Condition that must hold on every enabled clock edge.
`define PMFB_ASSERT_ALWAYS(label, clk_s, rst_n, cond, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define PMFB_ASSERT_IMPLIES(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PMFB_ASSERT_NEXT(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pmfb_pkg.sv =====
package pmfb_pkg;

	localparam int MAX_COLUMNS_DEF = 128;
	localparam int MAX_PAGES_DEF   = 8;
	localparam int GLYPH_WORDS_DEF = 2048;

	localparam int PAGE_ROWS = 8;

	localparam logic [7:0]  FIRST_GLYPH   = 8'd32;
	localparam logic [15:0] GLYPH_TOP_BIT = 16'h8000;
	localparam logic [7:0]  FILL_SET      = 8'hFF;
	localparam logic [7:0]  FILL_CLEAR    = 8'h00;

	localparam logic [7:0] RST_PANEL_WIDTH  = 8'd128;
	localparam logic [6:0] RST_PANEL_HEIGHT = 7'd64;
	localparam logic       RST_BACKGROUND   = 1'b0;
	localparam logic [4:0] RST_GLYPH_WIDTH  = 5'd7;
	localparam logic [5:0] RST_GLYPH_HEIGHT = 6'd10;

	typedef enum logic [2:0] {
		MODE_DRAW   = 3'd0,
		MODE_FILL   = 3'd1,
		MODE_CHAR   = 3'd2,
		MODE_CURSOR = 3'd3,
		MODE_READ   = 3'd4,
		MODE_FONT   = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_OOB       = 2'd1,
		STATUS_BAD_GLYPH = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CFG_PANEL_WIDTH  = 3'd0,
		CFG_PANEL_HEIGHT = 3'd1,
		CFG_BACKGROUND   = 3'd2,
		CFG_GLYPH_WIDTH  = 3'd3,
		CFG_GLYPH_HEIGHT = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic [2:0]  read_page;
		logic        colour;
		logic [7:0]  char_code;
		logic [10:0] font_addr;
		logic [15:0] font_bits;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] read_data;
	} rsp_item_t;

	typedef struct packed {
		logic [2:0] index;
		logic [7:0] value;
	} cfg_item_t;

endpackage

// ===== rtl/pmfb_if.sv =====
interface pmfb_cmd_if;
	import pmfb_pkg::*;
	logic      valid;
	logic      ready;
	cmd_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface pmfb_rsp_if;
	import pmfb_pkg::*;
	logic      valid;
	logic      ready;
	rsp_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface pmfb_cfg_if;
	import pmfb_pkg::*;
	logic      valid;
	logic      ready;
	cfg_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/paged_mono_framebuffer_engine.sv =====
// Paged monochrome frame buffer with glyph blit.
// Channels: cmd takes one item per operation (draw pixel, fill, write char,
// set cursor, read byte, load font row); rsp returns exactly one item
// (status, read_data) per cmd item, in order; cfg writes the panel and font
// registers (always ready) and may only be used while no cmd item is in flight.
// Frame bytes live in a MAX_COLUMNS*MAX_PAGES x 8 synchronous RAM, glyph rows in
// a GLYPH_WORDS x 16 RAM; a drawn or blitted pixel is a read then a write of one
// byte, and fill writes whole bytes. Steps after accept: set cursor, load font,
// unknown modes and rejected items finish in decode; draw pixel and read byte
// read the RAM in decode, then write the byte back or return it; fill sweeps
// every frame byte, one byte per cycle; write char fetches one glyph word per
// row, then reads and writes each pixel, or finishes in decode when either
// glyph size is zero. The result goes into the rsp register when that is free.
// After reset the block sweeps zeros through the frame RAM, one byte per cycle,
// with cmd.ready low; cfg writes are taken.
// rsp is a single output register: while it is stalled the block still accepts
// and works on the next item, then holds that result until the register frees.
`include "paged_mono_framebuffer_engine_assert.svh"

module paged_mono_framebuffer_engine #(
	parameter int MAX_COLUMNS = pmfb_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_PAGES   = pmfb_pkg::MAX_PAGES_DEF,
	parameter int GLYPH_WORDS = pmfb_pkg::GLYPH_WORDS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	pmfb_cmd_if.sink   cmd,
	pmfb_rsp_if.source rsp,
	pmfb_cfg_if.sink   cfg
);
	import pmfb_pkg::*;

	localparam int FRAME_BYTES = MAX_COLUMNS * MAX_PAGES;
	localparam int FB_AW       = $clog2(FRAME_BYTES);
	localparam int GL_AW       = $clog2(GLYPH_WORDS);
	localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
	localparam int ROWS        = MAX_PAGES * PAGE_ROWS;
	localparam int ROW_W       = $clog2(ROWS + 1);
	localparam logic [FB_AW-1:0] LAST_BYTE = FB_AW'(FRAME_BYTES - 1);

	typedef enum logic [8:0] {
		ST_CLEAR  = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_DECODE = 9'b000000100,
		ST_PIXWB  = 9'b000001000,
		ST_RDATA  = 9'b000010000,
		ST_GRD    = 9'b000100000,
		ST_PRD    = 9'b001000000,
		ST_PWR    = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	// memories
	logic [7:0]  fb_mem [FRAME_BYTES];
	logic [15:0] gl_mem [GLYPH_WORDS];

	// registers
	state_t     state_q, state_d;
	cmd_item_t  cmd_q;
	logic [7:0] pw_q;
	logic [6:0] ph_q;
	logic       bg_q;
	logic [4:0] gw_q;
	logic [5:0] gh_q;
	logic [7:0] cc_q, cc_d;
	logic [7:0] cr_q, cr_d;
	logic [14:0] base_q, base_d;
	logic [5:0] i_q, i_d;
	logic [4:0] j_q, j_d;
	logic [FB_AW-1:0] sweep_q, sweep_d;
	logic [7:0] fill_q, fill_d;
	logic       clr_fin_q, clr_fin_d;
	rsp_item_t  res_q, res_d;
	rsp_item_t  rsp_q, rsp_d;
	logic       rsp_valid_q;
	logic [7:0]  fb_rdata_q;
	logic [15:0] gl_rdata_q;

	// combinational
	logic [COL_W-1:0] w_eff;
	logic [ROW_W-1:0] h_eff;
	logic       blit_st;
	logic [8:0] blit_x, blit_y;
	logic [8:0] sel_x;
	logic [5:0] sel_page;
	logic [2:0] sel_bit;
	logic [15:0] addr_full;
	logic [FB_AW-1:0] fb_addr, fb_waddr;
	logic [7:0] fb_wdata, bit_mask, mod_byte;
	logic       pix_set, pix_on;
	logic       draw_oob, read_oob, char_oob, font_oob, code_low, glyph_over;
	logic [7:0] code_off;
	logic [14:0] base_full;
	logic [15:0] gl_sum, faddr_ext;
	logic [GL_AW-1:0] gl_raddr, gl_waddr;
	logic       fb_we, fb_clear_wr, gl_we, cmd_ld, fin, rsp_load, out_free;
	rsp_item_t  fin_item;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.item  = rsp_q;
	assign out_free  = !rsp_valid_q || rsp.ready;

	// panel clamped to the RAM geometry
	always_comb begin
		if (int'(pw_q) > MAX_COLUMNS) w_eff = COL_W'(MAX_COLUMNS);
		else w_eff = COL_W'(pw_q);
		if (int'(ph_q) > ROWS) h_eff = ROW_W'(ROWS);
		else h_eff = ROW_W'(ph_q);
	end

	assign blit_st = state_q inside {ST_PRD, ST_PWR};
	assign blit_x  = 9'(cc_q) + 9'(j_q);
	assign blit_y  = 9'(cr_q) + 9'(i_q);

	always_comb begin
		if (blit_st) begin
			sel_x    = blit_x;
			sel_page = blit_y[8:3];
			sel_bit  = blit_y[2:0];
		end else if (cmd_q.mode == MODE_READ) begin
			sel_x    = 9'(cmd_q.pos_x);
			sel_page = 6'(cmd_q.read_page);
			sel_bit  = 3'd0;
		end else begin
			sel_x    = 9'(cmd_q.pos_x);
			sel_page = 6'(cmd_q.pos_y[7:3]);
			sel_bit  = cmd_q.pos_y[2:0];
		end
	end

	assign addr_full = 16'(sel_x) + 16'(sel_page) * 16'(w_eff);
	assign fb_addr   = addr_full[FB_AW-1:0];
	assign fb_waddr  = fb_clear_wr ? sweep_q : fb_addr;
	assign fb_wdata  = fb_clear_wr ? fill_q : mod_byte;

	// glyph row is held in gl_rdata_q for the whole row, bit 15 is column 0
	assign pix_set  = !j_q[4] && (((gl_rdata_q << j_q[3:0]) & GLYPH_TOP_BIT) != 16'h0);
	assign pix_on   = blit_st ? (pix_set ? !bg_q : bg_q) : cmd_q.colour;
	assign bit_mask = 8'h01 << sel_bit;
	assign mod_byte = pix_on ? (fb_rdata_q | bit_mask) : (fb_rdata_q & ~bit_mask);

	assign draw_oob = (int'(cmd_q.pos_x) >= int'(w_eff)) || (int'(cmd_q.pos_y) >= int'(h_eff));
	assign read_oob = (int'(cmd_q.pos_x) >= int'(w_eff)) || (int'(cmd_q.read_page) >= MAX_PAGES)
		|| (int'({cmd_q.read_page, 3'b000}) >= int'(h_eff));
	assign char_oob = (int'(w_eff) <= int'(cc_q) + int'(gw_q))
		|| (int'(h_eff) <= int'(cr_q) + int'(gh_q));
	assign code_low   = cmd_q.char_code < FIRST_GLYPH;
	assign code_off   = cmd_q.char_code - FIRST_GLYPH;
	assign base_full  = 15'(code_off) * 15'(gh_q);
	assign glyph_over = (gh_q != 6'd0) && (int'(base_full) + int'(gh_q) > GLYPH_WORDS);
	assign font_oob   = int'(cmd_q.font_addr) >= GLYPH_WORDS;

	assign gl_sum    = 16'(base_q) + 16'(i_q);
	assign gl_raddr  = gl_sum[GL_AW-1:0];
	assign faddr_ext = 16'(cmd_q.font_addr);
	assign gl_waddr  = faddr_ext[GL_AW-1:0];

	always_comb begin
		state_d   = state_q;
		cc_d      = cc_q;
		cr_d      = cr_q;
		base_d    = base_q;
		i_d       = i_q;
		j_d       = j_q;
		sweep_d   = sweep_q;
		fill_d    = fill_q;
		clr_fin_d = clr_fin_q;
		res_d     = res_q;
		rsp_d     = rsp_q;
		fin       = 1'b0;
		fin_item  = '0;
		rsp_load  = 1'b0;
		fb_we     = 1'b0;
		fb_clear_wr = 1'b0;
		gl_we     = 1'b0;
		cmd_ld    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				fb_we       = 1'b1;
				fb_clear_wr = 1'b1;
				if (sweep_q == LAST_BYTE) begin
					if (clr_fin_q) fin = 1'b1;
					else state_d = ST_IDLE;
				end else begin
					sweep_d = sweep_q + FB_AW'(1);
				end
			end
			ST_IDLE: begin
				if (cmd.valid) begin
					cmd_ld  = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (cmd_q.mode)
					MODE_DRAW: begin
						if (draw_oob) begin
							fin = 1'b1;
							fin_item.status = STATUS_OOB;
						end else begin
							state_d = ST_PIXWB;
						end
					end
					MODE_FILL: begin
						fill_d    = cmd_q.colour ? FILL_SET : FILL_CLEAR;
						sweep_d   = '0;
						clr_fin_d = 1'b1;
						state_d   = ST_CLEAR;
					end
					MODE_CHAR: begin
						if (char_oob) begin
							fin = 1'b1;
							fin_item.status = STATUS_OOB;
						end else if (code_low || glyph_over) begin
							fin = 1'b1;
							fin_item.status = STATUS_BAD_GLYPH;
						end else if (gh_q == 6'd0 || gw_q == 5'd0) begin
							// nothing to paint, cursor still moves
							cc_d = cc_q + 8'(gw_q);
							fin  = 1'b1;
						end else begin
							base_d  = base_full;
							i_d     = '0;
							j_d     = '0;
							state_d = ST_GRD;
						end
					end
					MODE_CURSOR: begin
						cc_d = cmd_q.pos_x;
						cr_d = cmd_q.pos_y;
						fin  = 1'b1;
					end
					MODE_READ: begin
						if (read_oob) begin
							fin = 1'b1;
							fin_item.status = STATUS_OOB;
						end else begin
							state_d = ST_RDATA;
						end
					end
					MODE_FONT: begin
						if (font_oob) begin
							fin_item.status = STATUS_OOB;
						end else begin
							gl_we = 1'b1;
						end
						fin = 1'b1;
					end
					default: fin = 1'b1;
				endcase
			end
			ST_PIXWB: begin
				fb_we = 1'b1;
				fin   = 1'b1;
			end
			ST_RDATA: begin
				fin = 1'b1;
				fin_item.read_data = fb_rdata_q;
			end
			ST_GRD: state_d = ST_PRD;
			ST_PRD: state_d = ST_PWR;
			ST_PWR: begin
				// write lands before the next pixel read is issued, no overlap
				fb_we = 1'b1;
				if (j_q + 5'd1 == gw_q) begin
					j_d = '0;
					if (i_q + 6'd1 == gh_q) begin
						cc_d = cc_q + 8'(gw_q);
						fin  = 1'b1;
					end else begin
						i_d     = i_q + 6'd1;
						state_d = ST_GRD;
					end
				end else begin
					j_d     = j_q + 5'd1;
					state_d = ST_PRD;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					rsp_load = 1'b1;
					rsp_d    = res_q;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (fin) begin
			if (out_free) begin
				rsp_load = 1'b1;
				rsp_d    = fin_item;
				state_d  = ST_IDLE;
			end else begin
				res_d   = fin_item;
				state_d = ST_DONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fb_we) fb_mem[fb_waddr] <= fb_wdata;
		fb_rdata_q <= fb_mem[fb_addr];
	end

	always_ff @(posedge clk) begin
		if (gl_we) gl_mem[gl_waddr] <= cmd_q.font_bits;
		gl_rdata_q <= gl_mem[gl_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sweep_q     <= '0;
			fill_q      <= FILL_CLEAR;
			clr_fin_q   <= 1'b0;
			cc_q        <= '0;
			cr_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			rsp_valid_q <= 1'b0;
			pw_q        <= RST_PANEL_WIDTH;
			ph_q        <= RST_PANEL_HEIGHT;
			bg_q        <= RST_BACKGROUND;
			gw_q        <= RST_GLYPH_WIDTH;
			gh_q        <= RST_GLYPH_HEIGHT;
		end else begin
			state_q   <= state_d;
			sweep_q   <= sweep_d;
			fill_q    <= fill_d;
			clr_fin_q <= clr_fin_d;
			cc_q      <= cc_d;
			cr_q      <= cr_d;
			i_q       <= i_d;
			j_q       <= j_d;
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
			if (cfg.valid) begin
				case (cfg.item.index)
					CFG_PANEL_WIDTH:  pw_q <= cfg.item.value;
					CFG_PANEL_HEIGHT: ph_q <= cfg.item.value[6:0];
					CFG_BACKGROUND:   bg_q <= cfg.item.value[0];
					CFG_GLYPH_WIDTH:  gw_q <= cfg.item.value[4:0];
					CFG_GLYPH_HEIGHT: gh_q <= cfg.item.value[5:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ld) cmd_q <= cmd.item;
		base_q <= base_d;
		res_q  <= res_d;
		rsp_q  <= rsp_d;
	end

	`PMFB_ASSERT_IMPLIES(a_clear_blocks_cmd, clk, arst_n, state_q == ST_CLEAR, !cmd.ready,
		"cmd accepted during frame sweep")
	`PMFB_ASSERT_IMPLIES(a_pixel_addr_in_ram, clk, arst_n, fb_we && !fb_clear_wr,
		int'(addr_full) < FRAME_BYTES, "pixel write outside frame RAM")
	`PMFB_ASSERT_IMPLIES(a_blit_in_panel, clk, arst_n, state_q == ST_PWR,
		(int'(blit_x) < int'(w_eff)) && (int'(blit_y) < int'(h_eff)), "glyph pixel outside panel")
	`PMFB_ASSERT_NEXT(a_result_follows_fin, clk, arst_n, fin && out_free, rsp.valid,
		"finished item not presented")

endmodule

// ===== test/paged_mono_framebuffer_engine_test.sv =====
module paged_mono_framebuffer_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pmfb_pkg::*;

	localparam int FRAME_BYTES = MAX_COLUMNS_DEF * MAX_PAGES_DEF;
	localparam int GLYPH_WORDS = GLYPH_WORDS_DEF;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n;

	pmfb_cmd_if cmd_bus ();
	pmfb_rsp_if rsp_bus ();
	pmfb_cfg_if cfg_bus ();

	paged_mono_framebuffer_engine i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_bus),
		.rsp   (rsp_bus),
		.cfg   (cfg_bus)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the frame buffer, glyph store, cursor and registers
	logic [7:0]  frame_img [FRAME_BYTES];
	logic [15:0] font_img [GLYPH_WORDS];
	bit          font_known [GLYPH_WORDS];
	logic [7:0]  cur_col, cur_row;
	logic [7:0]  width_reg;
	logic [6:0]  height_reg;
	logic        bg_reg;
	logic [4:0]  gw_reg;
	logic [5:0]  gh_reg;

	rsp_item_t due_replies [$];
	int        mismatches = 0;
	int        cycle_count = 0;
	int        burst_left = 0;
	int        stall_style = 0;
	int        stall_span = 0;

	function automatic void reset_model();
		foreach (frame_img[i]) frame_img[i] = FILL_CLEAR;
		foreach (font_known[i]) font_known[i] = 1'b0;
		cur_col = '0;
		cur_row = '0;
		width_reg = RST_PANEL_WIDTH;
		height_reg = RST_PANEL_HEIGHT;
		bg_reg = RST_BACKGROUND;
		gw_reg = RST_GLYPH_WIDTH;
		gh_reg = RST_GLYPH_HEIGHT;
	endfunction

	function automatic int unsigned panel_cols();
		return (width_reg > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : width_reg;
	endfunction

	function automatic int unsigned panel_rows();
		return (height_reg > MAX_PAGES_DEF * PAGE_ROWS) ? MAX_PAGES_DEF * PAGE_ROWS : height_reg;
	endfunction

	function automatic void put_pixel(int unsigned x, int unsigned y, bit on);
		int unsigned idx;
		idx = x + (y / PAGE_ROWS) * panel_cols();
		if (idx < FRAME_BYTES)
			frame_img[idx][y % PAGE_ROWS] = on;
	endfunction

	// strict fit: the glyph must end before the last column and row
	function automatic bit glyph_fits();
		return (int'(cur_col) + int'(gw_reg) < int'(panel_cols())) &&
			(int'(cur_row) + int'(gh_reg) < int'(panel_rows()));
	endfunction

	function automatic int unsigned glyph_base(logic [7:0] code);
		return (int'(code) - int'(FIRST_GLYPH)) * int'(gh_reg);
	endfunction

	function automatic bit glyph_in_store(logic [7:0] code);
		if (code < FIRST_GLYPH)
			return 1'b0;
		return (gh_reg == 0) || (glyph_base(code) + gh_reg - 1 < GLYPH_WORDS);
	endfunction

	function automatic rsp_item_t apply_command(cmd_item_t c);
		rsp_item_t r;
		int unsigned cols, rows, base;
		logic [15:0] word;
		bit lit;
		r.status = STATUS_OK;
		r.read_data = '0;
		cols = panel_cols();
		rows = panel_rows();
		case (c.mode)
			MODE_DRAW: begin
				if (c.pos_x >= cols || c.pos_y >= rows)
					r.status = STATUS_OOB;
				else
					put_pixel(c.pos_x, c.pos_y, c.colour);
			end
			MODE_FILL: begin
				foreach (frame_img[i]) frame_img[i] = c.colour ? FILL_SET : FILL_CLEAR;
			end
			MODE_CHAR: begin
				if (!glyph_fits()) begin
					r.status = STATUS_OOB;
				end else if (!glyph_in_store(c.char_code)) begin
					r.status = STATUS_BAD_GLYPH;
				end else begin
					base = glyph_base(c.char_code);
					for (int i = 0; i < gh_reg; i++) begin
						word = font_img[base + i];
						for (int j = 0; j < gw_reg; j++) begin
							// columns past bit 0 are background
							lit = (j < 16) && word[15 - j];
							put_pixel(cur_col + j, cur_row + i, lit ? !bg_reg : bg_reg);
						end
					end
					cur_col = cur_col + gw_reg;
				end
			end
			MODE_CURSOR: begin
				cur_col = c.pos_x;
				cur_row = c.pos_y;
			end
			MODE_READ: begin
				if (c.pos_x >= cols || c.read_page * PAGE_ROWS >= rows)
					r.status = STATUS_OOB;
				else
					r.read_data = frame_img[c.pos_x + c.read_page * cols];
			end
			MODE_FONT: begin
				font_img[c.font_addr] = c.font_bits;
				font_known[c.font_addr] = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic cmd_item_t random_cmd(logic [2:0] mode);
		logic [63:0] raw;
		cmd_item_t c;
		raw = {$urandom, $urandom};
		c = raw[$bits(cmd_item_t)-1:0];
		c.mode = mode;
		return c;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_cmd(input cmd_item_t c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				cmd_bus.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		cmd_bus.valid <= 1'b1;
		cmd_bus.item <= c;
		do @(posedge clk); while (cmd_bus.ready !== 1'b1);
		due_replies.push_back(apply_command(c));
		@(negedge clk);
	endtask

	// always waits for a falling edge before returning, so valid is never dropped and raised in one step
	task automatic wait_drain();
		cmd_bus.valid <= 1'b0;
		do @(negedge clk); while (due_replies.size() != 0);
	endtask

	task automatic write_reg(cfg_index_t idx, int val);
		cfg_item_t w;
		w.index = idx;
		w.value = 8'(val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.item <= w;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		case (idx)
			CFG_PANEL_WIDTH: width_reg = w.value;
			CFG_PANEL_HEIGHT: height_reg = w.value[6:0];
			CFG_BACKGROUND: bg_reg = w.value[0];
			CFG_GLYPH_WIDTH: gw_reg = w.value[4:0];
			CFG_GLYPH_HEIGHT: gh_reg = w.value[5:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_panel(int w, int h, int bg, int gw, int gh);
		wait_drain();
		write_reg(CFG_PANEL_WIDTH, w);
		write_reg(CFG_PANEL_HEIGHT, h);
		write_reg(CFG_BACKGROUND, bg);
		write_reg(CFG_GLYPH_WIDTH, gw);
		write_reg(CFG_GLYPH_HEIGHT, gh);
	endtask

	task automatic draw_at(int x, int y, bit colour);
		cmd_item_t c;
		c = random_cmd(MODE_DRAW);
		c.pos_x = 8'(x);
		c.pos_y = 8'(y);
		c.colour = colour;
		send_cmd(c);
	endtask

	task automatic read_at(int x, int page);
		cmd_item_t c;
		c = random_cmd(MODE_READ);
		c.pos_x = 8'(x);
		c.read_page = 3'(page);
		send_cmd(c);
	endtask

	task automatic cursor_to(int x, int y);
		cmd_item_t c;
		c = random_cmd(MODE_CURSOR);
		c.pos_x = 8'(x);
		c.pos_y = 8'(y);
		send_cmd(c);
	endtask

	task automatic load_row(int addr, int unsigned bits);
		cmd_item_t c;
		c = random_cmd(MODE_FONT);
		c.font_addr = 11'(addr);
		c.font_bits = 16'(bits);
		send_cmd(c);
	endtask

	task automatic fill_with(bit colour);
		cmd_item_t c;
		c = random_cmd(MODE_FILL);
		c.colour = colour;
		send_cmd(c);
	endtask

	// a blit that will really draw first gets any glyph rows it reads loaded
	task automatic send_char(logic [7:0] code);
		cmd_item_t c;
		int unsigned base;
		if (glyph_fits() && glyph_in_store(code)) begin
			base = glyph_base(code);
			for (int i = 0; i < gh_reg; i++)
				if (!font_known[base + i])
					load_row(base + i, $urandom);
		end
		c = random_cmd(MODE_CHAR);
		c.char_code = code;
		send_cmd(c);
	endtask

	task automatic cursor_to_fit();
		int cols, rows;
		cols = panel_cols();
		rows = panel_rows();
		if (cols > gw_reg && rows > gh_reg)
			cursor_to($urandom_range(0, cols - gw_reg - 1), $urandom_range(0, rows - gh_reg - 1));
		else
			cursor_to($urandom_range(0, 255), $urandom_range(0, 255));
	endtask

	function automatic logic [7:0] pick_code();
		int unsigned r, span;
		r = $urandom_range(0, 99);
		span = (gh_reg > 16) ? 1 : 12;
		if (r < 12)
			return 8'($urandom_range(0, int'(FIRST_GLYPH) - 1));
		if (r < 95)
			return 8'(FIRST_GLYPH + $urandom_range(0, span));
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly in or just past the panel, sometimes anywhere in the field
	function automatic int near(int unsigned extent);
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 255);
		return $urandom_range(0, extent);
	endfunction

	task automatic send_random_item();
		int unsigned pick;
		cmd_item_t c;
		pick = $urandom_range(0, 99);
		if (pick < 24) begin
			draw_at(near(panel_cols()), near(panel_rows()), 1'($urandom_range(0, 1)));
		end else if (pick < 44) begin
			read_at(near(panel_cols()), $urandom_range(0, 7));
		end else if (pick < 66) begin
			if (!glyph_fits() && $urandom_range(0, 3) != 0)
				cursor_to_fit();
			send_char(pick_code());
		end else if (pick < 76) begin
			cursor_to(near(panel_cols()), near(panel_rows()));
		end else if (pick < 90) begin
			load_row($urandom_range(0, GLYPH_WORDS - 1), $urandom);
		end else if (pick < 93) begin
			fill_with(1'($urandom_range(0, 1)));
		end else if (pick < 96) begin
			c = random_cmd($urandom_range(0, 1) ? MODE_UNUSED_HI : MODE_UNUSED_LO);
			send_cmd(c);
		end else begin
			c = random_cmd(3'($urandom_range(0, 7)));
			// a blit goes through send_char so its glyph rows are loaded first
			if (c.mode == MODE_CHAR)
				send_char(c.char_code);
			else
				send_cmd(c);
		end
	endtask

	task automatic test_cleared_after_reset();
		read_at(0, 0);
		read_at(MAX_COLUMNS_DEF - 1, MAX_PAGES_DEF - 1);
	endtask

	task automatic test_directed_cases();
		draw_at(0, 0, 1'b1);
		draw_at(127, 63, 1'b1);
		draw_at(128, 0, 1'b1);
		draw_at(0, 64, 1'b1);
		draw_at(255, 255, 1'b0);
		read_at(0, 0);
		read_at(127, 7);
		read_at(128, 0);
		load_row(GLYPH_WORDS - 1, 16'hFFFF);
		send_char(FIRST_GLYPH - 8'd1);
		send_char(FIRST_GLYPH);
		send_char(8'hFF);
		cursor_to(121, 0);
		// bounds are checked before the glyph code
		send_char(FIRST_GLYPH - 8'd1);
		fill_with(1'b1);
		read_at(64, 3);
		fill_with(1'b0);
		send_cmd(random_cmd(MODE_UNUSED_LO));
		send_cmd(random_cmd(MODE_UNUSED_HI));
	endtask

	task automatic test_text_lines();
		apply_panel(128, 64, 1, 6, 8);
		fill_with(1'b1);
		for (int line = 0; line < 2; line++) begin
			cursor_to(0, line * 40);
			while (glyph_fits())
				send_char(8'(FIRST_GLYPH + $urandom_range(0, 9)));
			send_char(FIRST_GLYPH);
		end
		repeat (16) read_at($urandom_range(0, 127), $urandom_range(0, 7));
		apply_panel(100, 40, 0, 5, 7);
		cursor_to(2, 3);
		while (glyph_fits())
			send_char(8'(FIRST_GLYPH + $urandom_range(0, 4)));
		repeat (10) read_at($urandom_range(0, 99), $urandom_range(0, 4));
	endtask

	task automatic test_register_sweep();
		int phase_w [9] = '{128, 255, 0, 128, 1, 100, 128, 128, 128};
		int phase_h [9] = '{64, 127, 64, 0, 1, 40, 64, 64, 64};
		int phase_bg [9] = '{0, 1, 0, 1, 0, 1, 0, 1, 0};
		int phase_gw [9] = '{7, 16, 7, 7, 1, 31, 0, 20, 8};
		int phase_gh [9] = '{10, 16, 10, 10, 1, 6, 0, 63, 8};
		foreach (phase_w[p]) begin
			apply_panel(phase_w[p], phase_h[p], phase_bg[p], phase_gw[p], phase_gh[p]);
			repeat (p == 7 ? 20 : 40) send_random_item();
		end
		repeat (4) begin
			apply_panel($urandom_range(1, 128), $urandom_range(1, 64), $urandom_range(0, 1),
				$urandom_range(1, 16), $urandom_range(1, 32));
			repeat (45) send_random_item();
		end
	endtask

	task automatic test_pause_for_replies();
		apply_panel(128, 64, 0, 7, 10);
		repeat (25) send_random_item();
		wait_drain();
		repeat (25) send_random_item();
	endtask

	task automatic log_mismatch(bit orphan, rsp_item_t want, rsp_item_t got);
		mismatches++;
		if (mismatches <= 10) begin
			if (orphan)
				$display("reply with none due: status %0d data %02h", got.status, got.read_data);
			else
				$display("reply mismatch: expected status %0d data %02h, got status %0d data %02h",
					want.status, want.read_data, got.status, got.read_data);
		end
	endtask

	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
			if (due_replies.size() == 0) begin
				log_mismatch(1'b1, '0, rsp_bus.item);
			end else begin
				want = due_replies.pop_front();
				if (rsp_bus.item.status !== want.status || rsp_bus.item.read_data !== want.read_data)
					log_mismatch(1'b0, want, rsp_bus.item);
			end
		end
	end

	// reply stalls in spans: none, light, heavy
	initial begin
		rsp_bus.ready = 1'b0;
		forever begin
			if (stall_span == 0) begin
				stall_style = $urandom_range(0, 2);
				stall_span = $urandom_range(20, 300);
			end
			stall_span--;
			@(negedge clk);
			case (stall_style)
				0: rsp_bus.ready <= 1'b1;
				1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
				default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("paged_mono_framebuffer_engine_test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.item = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.item = '0;
		reset_model();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_cleared_after_reset();
		test_directed_cases();
		test_text_lines();
		test_register_sweep();
		test_pause_for_replies();
		wait_drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && due_replies.size() == 0)
			$display("paged_mono_framebuffer_engine_test passed");
		else
			$display("paged_mono_framebuffer_engine_test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pmfb_pkg.sv
rtl/pmfb_if.sv
rtl/paged_mono_framebuffer_engine.sv
test/paged_mono_framebuffer_engine_test.sv
